>>> rtl/ntqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntqs_pkg
// Shared types and constants for the note timing quantiser with swing.
// ----------------------------------------------------------------------------
package ntqs_pkg;

    localparam int unsigned FIELD_W    = 31;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 31'h7FFF_FFFF;

    // swing = unit * percent / 300, done as multiply by floor(2^32 / 300)
    localparam logic [8:0]  SWING_DIV   = 9'd300;
    localparam logic [23:0] SWING_RECIP = 24'd14316557;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // ceil(2^48 / 100): exact truncating /100 for magnitudes below 2^41
    localparam logic [41:0] PCT_RECIP = 42'd2814749767107;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_UNIT = 3'd0,
        REG_QUANT_DUR = 3'd1,
        REG_SWING     = 3'd2,
        REG_STRENGTH  = 3'd3,
        REG_MIN_LEN   = 3'd4,
        REG_SHORTEST  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [FIELD_W-1:0] event_time;
        logic [FIELD_W-1:0] bar_start;
        logic [FIELD_W-1:0] event_length;
        logic               is_note;
    } t_evt_in;

    typedef struct packed {
        logic               erase_event;
        logic [FIELD_W-1:0] new_time;
        logic [FIELD_W-1:0] new_length;
        logic               changed;
    } t_evt_out;

endpackage

>>> rtl/ntqs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntqs_in_if
// Valid/ready channel carrying one note event item.
// ----------------------------------------------------------------------------
interface ntqs_in_if;
    import ntqs_pkg::*;

    logic    valid;
    logic    ready;
    t_evt_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ntqs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntqs_out_if
// Valid/ready channel carrying one quantised result item.
// ----------------------------------------------------------------------------
interface ntqs_out_if;
    import ntqs_pkg::*;

    logic     valid;
    logic     ready;
    t_evt_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ntqs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntqs_div
// Pipelined restoring divider, one quotient bit per stage, L lanes sharing
// one divisor, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module ntqs_div #(
    parameter int unsigned W  = 31,
    parameter int unsigned DW = 16,
    parameter int unsigned L  = 2,
    parameter int unsigned PW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [L-1:0][W-1:0]       i_dividend,
    input  logic [DW-1:0]             i_divisor,
    input  logic [PW-1:0]             i_payload,
    output logic                      o_valid,
    output logic [L-1:0][W-1:0]       o_quot,
    output logic [L-1:0][DW-1:0]      o_rem,
    output logic [PW-1:0]             o_payload
);
    // shift word: dividend bits leave at the top, quotient bits enter below
    logic                  r_v   [W];
    logic [L-1:0][W-1:0]   r_sh  [W];
    logic [L-1:0][DW-1:0]  r_rem [W];
    logic [DW-1:0]         r_dv  [W];
    logic [PW-1:0]         r_pl  [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic                 c_v;
        logic [L-1:0][W-1:0]  c_sh;
        logic [L-1:0][DW-1:0] c_rem;
        logic [DW-1:0]        c_dv;
        logic [PW-1:0]        c_pl;
        logic [L-1:0][W-1:0]  n_sh;
        logic [L-1:0][DW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_sh  = i_dividend;
            assign c_rem = '0;
            assign c_dv  = i_divisor;
            assign c_pl  = i_payload;
        end else begin : g_next
            assign c_v   = r_v[s-1];
            assign c_sh  = r_sh[s-1];
            assign c_rem = r_rem[s-1];
            assign c_dv  = r_dv[s-1];
            assign c_pl  = r_pl[s-1];
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;
            always_comb begin
                trial       = {c_rem[l], c_sh[l][W-1]};
                diff        = trial - {1'b0, c_dv};
                ge          = trial >= {1'b0, c_dv};
                n_rem[l]    = ge ? diff[DW-1:0] : trial[DW-1:0];
                n_sh[l]     = {c_sh[l][W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[s]  <= n_sh;
                r_rem[s] <= n_rem;
                r_dv[s]  <= c_dv;
                r_pl[s]  <= c_pl;
            end
        end
    end

    assign o_valid   = r_v[W-1];
    assign o_quot    = r_sh[W-1];
    assign o_rem     = r_rem[W-1];
    assign o_payload = r_pl[W-1];
endmodule

>>> rtl/note_timing_quantizer_swing.sv
`timescale 1ns / 1ps
// Pipeline: stage 0, grid divider, stages A, B, C, D, E, P, Q, F, G, output H.
// Throughput: one item per cycle unless stalled; the bit-per-stage grid-unit
//   divider (31 stages) sets most of the depth; /100 is a two-stage reciprocal.
// Stall: the whole pipeline holds while the output register is full and unread.
// Reset: synchronous, active low; clears valid bits and loads the register
//   defaults (grid 60, swing 0, strength 100, shortest note 60).
// ----------------------------------------------------------------------------
// note_timing_quantizer_swing
// Snaps note start ticks (and optionally lengths) to a grid with swing and
// partial strength, erasing notes that are too short.
// ----------------------------------------------------------------------------
module note_timing_quantizer_swing (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ntqs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ntqs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ntqs_in_if.sink                             i_evt,
    ntqs_out_if.source                          o_res
);
    import ntqs_pkg::*;

    localparam int unsigned TS_W = 33;  // relative start after rounding
    localparam int unsigned FT_W = 34;  // fully quantised absolute values
    localparam int unsigned DF_W = 35;  // distance moved
    localparam int unsigned PR_W = 43;  // distance times strength
    localparam int unsigned MG_W = 41;  // magnitude into the /100
    localparam int unsigned P1_W = 3 + 3 * FIELD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]       r_grid_unit;
    logic              r_quant_dur;
    logic signed [7:0] r_swing_pct;
    logic [6:0]        r_strength;
    logic [15:0]       r_min_len;
    logic [15:0]       r_shortest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_unit <= 16'd60;
            r_quant_dur <= 1'b0;
            r_swing_pct <= 8'sd0;
            r_strength  <= PCT_FULL;
            r_min_len   <= 16'd0;
            r_shortest  <= 16'd60;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_GRID_UNIT: r_grid_unit <= i_cfg_data;
                REG_QUANT_DUR: r_quant_dur <= i_cfg_data[0];
                REG_SWING:     r_swing_pct <= $signed(i_cfg_data[7:0]);
                REG_STRENGTH:  r_strength  <= i_cfg_data[6:0];
                REG_MIN_LEN:   r_min_len   <= i_cfg_data;
                REG_SHORTEST:  r_shortest  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Swing offset: depends on configuration only, so it runs freely.
    // Settles long before any item reaches stage B.
    // ------------------------------------------------------------------
    logic signed [24:0] r_sw_prod;
    logic [23:0]        r_sw_mag;
    logic               r_sw_neg;
    logic [23:0]        r_sw_mag2;
    logic               r_sw_neg2;
    logic [15:0]        r_sw_est;
    logic signed [15:0] r_swing;
    logic [24:0]        n_sw_abs;
    logic [47:0]        n_sw_recip;
    logic [24:0]        n_sw_rem;
    logic [15:0]        n_sw_q;

    always_comb begin
        n_sw_abs   = r_sw_prod[24] ? 25'(-r_sw_prod) : 25'(r_sw_prod);
        n_sw_recip = r_sw_mag * SWING_RECIP;
        // estimate is exact or one short
        n_sw_rem   = 25'(r_sw_mag2) - 25'(r_sw_est) * 25'(SWING_DIV);
        n_sw_q     = (n_sw_rem >= 25'(SWING_DIV)) ? r_sw_est + 16'd1 : r_sw_est;
    end

    always_ff @(posedge i_clk) begin
        r_sw_prod <= $signed({1'b0, r_grid_unit}) * r_swing_pct;
        r_sw_mag  <= n_sw_abs[23:0];
        r_sw_neg  <= r_sw_prod[24];
        r_sw_est  <= n_sw_recip[47:32];
        r_sw_mag2 <= r_sw_mag;
        r_sw_neg2 <= r_sw_neg;
        r_swing   <= r_sw_neg2 ? $signed(-n_sw_q) : $signed(n_sw_q);
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves together unless the output
    // register holds an item the sink has not taken.
    // ------------------------------------------------------------------
    logic     r_o_valid;
    t_evt_out r_o_data;
    logic     en;

    assign en          = !r_o_valid || o_res.ready;
    assign i_evt.ready = en;

    // ------------------------------------------------------------------
    // Stage 0: register the item, relative start, erase test
    // ------------------------------------------------------------------
    logic               r0_v;
    logic [FIELD_W-1:0] r0_otime, r0_bar, r0_olen, r0_tabs;
    logic               r0_neg, r0_erase, r0_pass;
    logic [FIELD_W:0]   n0_t;
    logic [FIELD_W:0]   n0_tabs;
    logic               n0_erase;

    always_comb begin
        n0_t     = {1'b0, i_evt.data.event_time} - {1'b0, i_evt.data.bar_start};
        n0_tabs  = n0_t[FIELD_W] ? -n0_t : n0_t;
        n0_erase = i_evt.data.is_note &&
                   ((i_evt.data.event_length == '0) ||
                    (i_evt.data.event_length < FIELD_W'(r_min_len)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_otime <= i_evt.data.event_time;
            r0_bar   <= i_evt.data.bar_start;
            r0_olen  <= i_evt.data.event_length;
            r0_tabs  <= n0_tabs[FIELD_W-1:0];
            r0_neg   <= n0_t[FIELD_W];
            r0_erase <= n0_erase;
            r0_pass  <= n0_erase || (r_grid_unit == '0);
        end
    end

    // ------------------------------------------------------------------
    // Divider 1: |start - bar| and length, both by grid unit
    // ------------------------------------------------------------------
    logic                          d1_v;
    logic [1:0][FIELD_W-1:0]       d1_q;
    logic [1:0][15:0]              d1_r;
    logic [P1_W-1:0]               d1_pl;
    logic                          p1_pass, p1_erase, p1_neg;
    logic [FIELD_W-1:0]            p1_otime, p1_bar, p1_olen;

    ntqs_div #(
        .W  (FIELD_W),
        .DW (16),
        .L  (2),
        .PW (P1_W)
    ) u_div_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r0_v),
        .i_dividend ({r0_olen, r0_tabs}),
        .i_divisor  (r_grid_unit),
        .i_payload  ({r0_pass, r0_erase, r0_neg, r0_otime, r0_bar, r0_olen}),
        .o_valid    (d1_v),
        .o_quot     (d1_q),
        .o_rem      (d1_r),
        .o_payload  (d1_pl)
    );

    assign {p1_pass, p1_erase, p1_neg, p1_otime, p1_bar, p1_olen} = d1_pl;

    // ------------------------------------------------------------------
    // Stage A: nearest cell for the start, grid rounding for the length.
    // A negative offset always lands on the cell towards zero.
    // ------------------------------------------------------------------
    logic                   rA_v;
    logic signed [TS_W-1:0] rA_tq, rA_dl;
    logic                   rA_odd, rA_dadd, rA_dsub;
    logic                   rA_pass, rA_erase;
    logic [FIELD_W-1:0]     rA_otime, rA_bar, rA_olen;
    logic signed [TS_W-1:0] nA_ts, nA_tq, nA_dbase, nA_dl;
    logic                   nA_odd, nA_dodd, nA_dadd, nA_dsub;

    always_comb begin
        nA_ts    = $signed({2'b0, p1_otime}) - $signed({2'b0, p1_bar});
        nA_dbase = $signed({2'b0, p1_olen}) - $signed(TS_W'(d1_r[1]));
        nA_dl    = $signed({2'b0, p1_olen});
        nA_dodd  = 1'b0;
        nA_dadd  = 1'b0;
        nA_dsub  = 1'b0;
        if (p1_neg) begin
            nA_tq  = nA_ts + $signed(TS_W'(d1_r[0]));
            nA_odd = d1_q[0][0];
        end else if ({1'b0, r_grid_unit} > {d1_r[0], 1'b0}) begin
            nA_tq  = nA_ts - $signed(TS_W'(d1_r[0]));
            nA_odd = d1_q[0][0];
        end else begin
            nA_tq  = nA_ts - $signed(TS_W'(d1_r[0])) + $signed(TS_W'(r_grid_unit));
            nA_odd = !d1_q[0][0];
        end
        if (r_quant_dur && (p1_olen != '0)) begin
            if ((d1_q[1] != '0) && ({1'b0, r_grid_unit} > {d1_r[1], 1'b0})) begin
                nA_dl   = nA_dbase;
                nA_dodd = d1_q[1][0];
            end else begin
                nA_dl   = nA_dbase + $signed(TS_W'(r_grid_unit));
                nA_dodd = !d1_q[1][0];
            end
            // end cell parity differs from start cell when length in cells is odd
            nA_dadd = nA_dodd && !nA_odd;
            nA_dsub = nA_dodd && nA_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
        end else if (en) begin
            rA_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rA_tq    <= nA_tq;
            rA_dl    <= nA_dl;
            rA_odd   <= nA_odd;
            rA_dadd  <= nA_dadd;
            rA_dsub  <= nA_dsub;
            rA_pass  <= p1_pass;
            rA_erase <= p1_erase;
            rA_otime <= p1_otime;
            rA_bar   <= p1_bar;
            rA_olen  <= p1_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: apply swing, back to absolute ticks
    // ------------------------------------------------------------------
    logic                   rB_v;
    logic signed [FT_W-1:0] rB_ft, rB_fd;
    logic                   rB_pass, rB_erase;
    logic [FIELD_W-1:0]     rB_otime, rB_olen;
    logic signed [FT_W-1:0] nB_sw, nB_fd;

    always_comb begin
        nB_sw = FT_W'(r_swing);
        nB_fd = FT_W'(rA_dl);
        if (rA_dadd) begin
            nB_fd = FT_W'(rA_dl) + nB_sw;
        end else if (rA_dsub) begin
            nB_fd = FT_W'(rA_dl) - nB_sw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_v <= 1'b0;
        end else if (en) begin
            rB_v <= rA_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rB_ft    <= FT_W'(rA_tq) + (rA_odd ? nB_sw : FT_W'(0))
                        + $signed({3'b0, rA_bar});
            rB_fd    <= nB_fd;
            rB_pass  <= rA_pass;
            rB_erase <= rA_erase;
            rB_otime <= rA_otime;
            rB_olen  <= rA_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: distance moved by full quantisation
    // ------------------------------------------------------------------
    logic                   rC_v;
    logic signed [DF_W-1:0] rC_dt, rC_dd;
    logic signed [FT_W-1:0] rC_ft, rC_fd;
    logic                   rC_pass, rC_erase;
    logic [FIELD_W-1:0]     rC_otime, rC_olen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_v <= 1'b0;
        end else if (en) begin
            rC_v <= rB_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_dt    <= DF_W'(rB_ft) - $signed({4'b0, rB_otime});
            rC_dd    <= DF_W'(rB_fd) - $signed({4'b0, rB_olen});
            rC_ft    <= rB_ft;
            rC_fd    <= rB_fd;
            rC_pass  <= rB_pass;
            rC_erase <= rB_erase;
            rC_otime <= rB_otime;
            rC_olen  <= rB_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: scale by strength
    // ------------------------------------------------------------------
    logic                   rD_v;
    logic signed [PR_W-1:0] rD_pt, rD_pd;
    logic signed [FT_W-1:0] rD_ft, rD_fd;
    logic                   rD_pass, rD_erase;
    logic [FIELD_W-1:0]     rD_otime, rD_olen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_v <= 1'b0;
        end else if (en) begin
            rD_v <= rC_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rD_pt    <= rC_dt * $signed({1'b0, r_strength});
            rD_pd    <= rC_dd * $signed({1'b0, r_strength});
            rD_ft    <= rC_ft;
            rD_fd    <= rC_fd;
            rD_pass  <= rC_pass;
            rD_erase <= rC_erase;
            rD_otime <= rC_otime;
            rD_olen  <= rC_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: sign and magnitude for the truncating /100
    // ------------------------------------------------------------------
    logic                   rE_v;
    logic [MG_W-1:0]        rE_mt, rE_md;
    logic                   rE_nt, rE_nd;
    logic signed [FT_W-1:0] rE_ft, rE_fd;
    logic                   rE_pass, rE_erase;
    logic [FIELD_W-1:0]     rE_otime, rE_olen;
    logic [PR_W-1:0]        nE_at, nE_ad;

    always_comb begin
        nE_at = rD_pt[PR_W-1] ? PR_W'(-rD_pt) : PR_W'(rD_pt);
        nE_ad = rD_pd[PR_W-1] ? PR_W'(-rD_pd) : PR_W'(rD_pd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rE_v <= 1'b0;
        end else if (en) begin
            rE_v <= rD_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rE_mt    <= nE_at[MG_W-1:0];
            rE_md    <= nE_ad[MG_W-1:0];
            rE_nt    <= rD_pt[PR_W-1];
            rE_nd    <= rD_pd[PR_W-1];
            rE_ft    <= rD_ft;
            rE_fd    <= rD_fd;
            rE_pass  <= rD_pass;
            rE_erase <= rD_erase;
            rE_otime <= rD_otime;
            rE_olen  <= rD_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage P: /100 by reciprocal, 21-bit partial products of the
    // magnitude times ceil(2^48 / 100)
    // ------------------------------------------------------------------
    logic                   rP_v;
    logic [41:0]            rP_tll, rP_tlh, rP_dll, rP_dlh;
    logic [40:0]            rP_thl, rP_thh, rP_dhl, rP_dhh;
    logic                   rP_pass, rP_erase, rP_nt, rP_nd;
    logic signed [FT_W-1:0] rP_ft, rP_fd;
    logic [FIELD_W-1:0]     rP_otime, rP_olen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP_v <= 1'b0;
        end else if (en) begin
            rP_v <= rE_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rP_tll   <= rE_mt[20:0] * PCT_RECIP[20:0];
            rP_tlh   <= rE_mt[20:0] * PCT_RECIP[41:21];
            rP_thl   <= rE_mt[MG_W-1:21] * PCT_RECIP[20:0];
            rP_thh   <= rE_mt[MG_W-1:21] * PCT_RECIP[41:21];
            rP_dll   <= rE_md[20:0] * PCT_RECIP[20:0];
            rP_dlh   <= rE_md[20:0] * PCT_RECIP[41:21];
            rP_dhl   <= rE_md[MG_W-1:21] * PCT_RECIP[20:0];
            rP_dhh   <= rE_md[MG_W-1:21] * PCT_RECIP[41:21];
            rP_pass  <= rE_pass;
            rP_erase <= rE_erase;
            rP_nt    <= rE_nt;
            rP_nd    <= rE_nd;
            rP_ft    <= rE_ft;
            rP_fd    <= rE_fd;
            rP_otime <= rE_otime;
            rP_olen  <= rE_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: sum the partial products, quotient is the top bits
    // ------------------------------------------------------------------
    logic                   rQ_v;
    logic [MG_W-1:0]        rQ_qt, rQ_qd;
    logic                   rQ_pass, rQ_erase, rQ_nt, rQ_nd;
    logic signed [FT_W-1:0] rQ_ft, rQ_fd;
    logic [FIELD_W-1:0]     rQ_otime, rQ_olen;
    logic [82:0]            nQ_st, nQ_sd;

    always_comb begin
        nQ_st = {rP_thh, 42'b0} + {20'b0, rP_tlh, 21'b0}
              + {21'b0, rP_thl, 21'b0} + {41'b0, rP_tll};
        nQ_sd = {rP_dhh, 42'b0} + {20'b0, rP_dlh, 21'b0}
              + {21'b0, rP_dhl, 21'b0} + {41'b0, rP_dll};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rQ_v <= 1'b0;
        end else if (en) begin
            rQ_v <= rP_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rQ_qt    <= MG_W'(nQ_st[82:48]);
            rQ_qd    <= MG_W'(nQ_sd[82:48]);
            rQ_pass  <= rP_pass;
            rQ_erase <= rP_erase;
            rQ_nt    <= rP_nt;
            rQ_nd    <= rP_nd;
            rQ_ft    <= rP_ft;
            rQ_fd    <= rP_fd;
            rQ_otime <= rP_otime;
            rQ_olen  <= rP_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: blended values
    // ------------------------------------------------------------------
    logic                   rF_v;
    logic signed [PR_W-1:0] rF_bt, rF_bd;
    logic signed [FT_W-1:0] rF_ft, rF_fd;
    logic                   rF_pass, rF_erase;
    logic [FIELD_W-1:0]     rF_otime, rF_olen;
    logic signed [PR_W-1:0] nF_qt, nF_qd;

    always_comb begin
        nF_qt = rQ_nt ? -$signed({2'b0, rQ_qt}) : $signed({2'b0, rQ_qt});
        nF_qd = rQ_nd ? -$signed({2'b0, rQ_qd}) : $signed({2'b0, rQ_qd});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rF_v <= 1'b0;
        end else if (en) begin
            rF_v <= rQ_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rF_bt    <= nF_qt + $signed({12'b0, rQ_otime});
            rF_bd    <= nF_qd + $signed({12'b0, rQ_olen});
            rF_ft    <= rQ_ft;
            rF_fd    <= rQ_fd;
            rF_pass  <= rQ_pass;
            rF_erase <= rQ_erase;
            rF_otime <= rQ_otime;
            rF_olen  <= rQ_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: snap window, strength bypass, saturation
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] sat_field(input logic signed [PR_W-1:0] v);
        logic [FIELD_W-1:0] res;
        begin
            if (v < 0) begin
                res = '0;
            end else if (v > $signed(PR_W'(FIELD_MAX))) begin
                res = FIELD_MAX;
            end else begin
                res = v[FIELD_W-1:0];
            end
            return res;
        end
    endfunction

    logic                   rG_v;
    logic [FIELD_W-1:0]     rG_time, rG_len;
    logic                   rG_pass, rG_erase;
    logic [FIELD_W-1:0]     rG_otime, rG_olen;
    logic signed [PR_W-1:0] nG_close, nG_ft, nG_fd, nG_et, nG_ed, nG_t, nG_d;

    always_comb begin
        nG_close = $signed({28'b0, r_shortest[15:1]});
        nG_ft    = PR_W'(rF_ft);
        nG_fd    = PR_W'(rF_fd);
        nG_et    = rF_bt - nG_ft;
        nG_ed    = rF_bd - nG_fd;
        nG_t     = nG_ft;
        nG_d     = nG_fd;
        if (r_strength != PCT_FULL) begin
            if (!((nG_et >= -nG_close) && (nG_et <= nG_close))) begin
                nG_t = rF_bt;
            end
            if (!((nG_ed >= -nG_close) && (nG_ed <= nG_close))) begin
                nG_d = rF_bd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rG_v <= 1'b0;
        end else if (en) begin
            rG_v <= rF_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rG_time  <= sat_field(nG_t);
            rG_len   <= sat_field(nG_d);
            rG_pass  <= rF_pass;
            rG_erase <= rF_erase;
            rG_otime <= rF_otime;
            rG_olen  <= rF_olen;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: output register; erased items and a zero grid echo input
    // ------------------------------------------------------------------
    t_evt_out n_o_data;

    always_comb begin
        n_o_data.erase_event = rG_erase;
        if (rG_pass) begin
            n_o_data.new_time   = rG_otime;
            n_o_data.new_length = rG_olen;
            n_o_data.changed    = 1'b0;
        end else begin
            n_o_data.new_time   = rG_time;
            n_o_data.new_length = rG_len;
            n_o_data.changed    = (rG_time != rG_otime) || (rG_len != rG_olen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= rG_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_data;
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the note timing quantiser: note events stream in
// under a series of register settings, each result item is compared with a
// bit-true prediction of grid snapping, swing, strength blending and erasure.
// ----------------------------------------------------------------------------
module tb_top;
    import ntqs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RAND_PER_SET = 92;

    // Expected result store plus the predictor's own copy of the registers.
    class quant_scoreboard;
        t_evt_out  expected_q[$];
        int        errors;
        int        checked;
        longint    grid_unit;
        bit        quant_dur;
        longint    swing_pct;
        longint    strength;
        longint    min_len;
        longint    shortest;

        function void reset_regs();
            grid_unit = 60;
            quant_dur = 0;
            swing_pct = 0;
            strength  = 100;
            min_len   = 0;
            shortest  = 60;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GRID_UNIT: grid_unit = val;
                REG_QUANT_DUR: quant_dur = val[0];
                REG_SWING:     swing_pct = $signed(val[7:0]);
                REG_STRENGTH:  strength  = val[6:0];
                REG_MIN_LEN:   min_len   = val;
                REG_SHORTEST:  shortest  = val;
                default: ;
            endcase
        endfunction

        function longint clamp31(longint v);
            if (v < 0) return 0;
            if (v > 64'sd2147483647) return 64'sd2147483647;
            return v;
        endfunction

        function t_evt_out quantise(t_evt_in e);
            longint   otime, bar, olen, t, d, grid_cell, swing, lo, hi, endcell, ft, fd, win;
            t_evt_out r;
            otime = e.event_time;
            bar   = e.bar_start;
            olen  = e.event_length;
            r.erase_event = 1'b0;
            r.new_time    = e.event_time;
            r.new_length  = e.event_length;
            r.changed     = 1'b0;
            if (e.is_note && (olen == 0 || olen < min_len)) begin
                r.erase_event = 1'b1;
                return r;
            end
            if (grid_unit == 0) return r;

            // nearest cell, ties go up; cell number truncates toward zero
            t         = otime - bar;
            grid_cell = t / grid_unit;
            lo        = grid_cell * grid_unit;
            hi        = lo + grid_unit;
            if (hi - t > t - lo) begin
                t = lo;
            end else begin
                t = hi;
                grid_cell++;
            end
            swing = (grid_unit * swing_pct) / 300;
            if (grid_cell[0]) t += swing;

            d = olen;
            if (quant_dur && d != 0) begin
                lo = (d / grid_unit) * grid_unit;
                hi = lo + grid_unit;
                if (lo > 0 && hi - d > d - lo) d = lo;
                else d = hi;
                endcell = grid_cell + d / grid_unit;
                if (!grid_cell[0] && endcell[0]) d += swing;
                else if (grid_cell[0] && !endcell[0]) d -= swing;
            end
            t += bar;

            // partial strength, with a snap window around the full result
            if (strength != 100) begin
                ft  = t;
                fd  = d;
                win = shortest / 2;
                t = (ft - otime) * strength / 100 + otime;
                d = (fd - olen) * strength / 100 + olen;
                if (t >= ft - win && t <= ft + win) t = ft;
                if (d >= fd - win && d <= fd + win) d = fd;
            end
            t = clamp31(t);
            d = clamp31(d);
            r.new_time   = t[FIELD_W-1:0];
            r.new_length = d[FIELD_W-1:0];
            r.changed    = (t != otime || d != olen);
            return r;
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, checked);
        endtask

        function void note_event(t_evt_in e);
            expected_q.push_back(quantise(e));
        endfunction

        task check_result(t_evt_out got);
            t_evt_out want;
            if (expected_q.size() == 0) begin
                report("unexpected item", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.erase_event !== want.erase_event)
                    report("erase_event", got.erase_event, want.erase_event);
                if (got.new_time !== want.new_time)
                    report("new_time", got.new_time, want.new_time);
                if (got.new_length !== want.new_length)
                    report("new_length", got.new_length, want.new_length);
                if (got.changed !== want.changed)
                    report("changed", got.changed, want.changed);
            end
            checked++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    idling;
    int                    cycles;
    int                    stall_left;
    int                    sent;

    quant_scoreboard sb;

    ntqs_in_if  evt_if ();
    ntqs_out_if res_if ();

    note_timing_quantizer_swing u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt_if.sink),
        .o_res      (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any hang or lost item ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles, sb.pending());
            $display("tb_top: errors");
            $finish;
        end
    end

    // Both channels sampled on the rising edge, before the design updates.
    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) sb.note_event(evt_if.data);
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
    end

    // Receiver back-pressure in random bursts while idling is on.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 11);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Entered and left at a falling edge; valid is left high after acceptance
    // so the next call decides whether to drop it.
    task send_event(t_evt_in e);
        if (idling && $urandom_range(0, 3) == 0) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.data  <= e;
        do @(posedge i_clk); while (!evt_if.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task send_fields(longint t, longint b, longint l, bit n);
        t_evt_in e;
        e.event_time   = t[FIELD_W-1:0];
        e.bar_start    = b[FIELD_W-1:0];
        e.event_length = l[FIELD_W-1:0];
        e.is_note      = n;
        send_event(e);
    endtask

    // Mostly sensible bar/event geometry, some negative offsets and raw noise.
    task send_random();
        t_evt_in e;
        int      mode;
        mode = $urandom_range(0, 9);
        e.is_note = $urandom_range(0, 1);
        if (mode == 0) begin
            e.event_time   = $urandom();
            e.bar_start    = $urandom();
            e.event_length = $urandom();
        end else begin
            e.bar_start  = $urandom_range(0, 31'h7FF0_0000);
            e.event_time = e.bar_start + $urandom_range(0, 8000);
            if (mode == 1) e.bar_start = e.event_time + $urandom_range(1, 5000);
            case ($urandom_range(0, 7))
                0:       e.event_length = $urandom_range(0, 3);
                1:       e.event_length = $urandom();
                default: e.event_length = $urandom_range(1, 4000);
            endcase
        end
        send_event(e);
    endtask

    // Only called with the block drained; each write holds for one cycle.
    task write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task drain();
        evt_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (90) @(negedge i_clk);
    endtask

    task load_regs(int g, int q, int sw, int st, int ml, int sh);
        logic [7:0] sw8;
        sw8 = 8'(sw);
        drain();
        write_reg(REG_GRID_UNIT, 16'(g));
        write_reg(REG_QUANT_DUR, 16'(q));
        write_reg(REG_SWING, {8'h00, sw8});
        write_reg(REG_STRENGTH, 16'(st));
        write_reg(REG_MIN_LEN, 16'(ml));
        write_reg(REG_SHORTEST, 16'(sh));
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task random_burst();
        repeat (RAND_PER_SET) send_random();
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        cycles       = 0;
        stall_left   = 0;
        sent         = 0;
        idling       = 1'b1;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        evt_if.valid = 1'b0;
        evt_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under reset defaults (grid 60, full strength).
        send_fields(100, 0, 0, 1);                          // zero-length note erased
        send_fields(100, 0, 0, 0);                          // zero-length non-note kept
        send_fields(0, 0, 1, 1);
        send_fields(30, 0, 50, 1);                          // exact half cell rounds up
        send_fields(29, 0, 50, 1);
        send_fields(91, 0, 60, 1);                          // starts in odd cell, snaps to cell 2
        send_fields(20, 500, 40, 1);                        // bar after the event
        send_fields(31'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 1);    // largest field values
        send_fields(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
        send_fields(0, 31'h7FFF_FFFF, 1, 0);                // large negative offset
        send_fields(31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA, 1);
        send_fields(31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555, 0);
        random_burst();

        load_regs(0, 1, 50, 100, 0, 60);                    // grid off: echo
        send_fields(1234, 1000, 77, 1);
        random_burst();
        load_regs(48, 1, 33, 100, 10, 60);
        send_fields(1000, 0, 9, 1);                         // shorter than minimum
        send_fields(1000, 0, 9, 0);
        random_burst();
        load_regs(120, 1, -100, 50, 0, 0);                  // no snap window
        random_burst();
        load_regs(65535, 1, 100, 0, 65535, 65535);          // widest extremes
        random_burst();
        load_regs(1, 1, -1, 127, 1, 1);                     // extrapolating strength
        random_burst();
        load_regs(96, 1, 66, 75, 20, 24);
        random_burst();

        // Final stretch runs at full rate on both sides.
        load_regs(60, 1, 50, 100, 0, 60);
        idling = 1'b0;
        random_burst();

        drain();
        $display("covered %0d items over eight register settings, %0d results checked",
                 sent, sb.checked);
        $display("grid off, swing both ways, strength 0 to 127, erasure and saturation");
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
